@@ rtl/core/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Types, constants and codes for the sorted interval table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int Capacity    = 32;
    localparam int KeyBits     = 32;
    localparam int MaxResults  = 32;
    localparam int IdxBits     = $clog2(Capacity);
    localparam int CntBits     = $clog2(Capacity + 1);

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_PRED   = 3'd3;
    localparam logic [2:0] CMD_SUCC   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DENIED   = 3'd4;

    localparam logic [31:0] KeyMask = (KeyBits >= 32) ? 32'hFFFF_FFFF
                                    : ((32'd1 << KeyBits) - 32'd1);

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] left_end;
        logic [31:0] right_end;
        logic [63:0] owner_id;
        logic [31:0] query_point;
        logic [5:0]  match_limit;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] out_left;
        logic [31:0] out_right;
        logic [63:0] out_owner;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [63:0] owner;
    } t_entry;

    // Comparison results of the shared compare unit.
    typedef struct packed {
        logic key_lt;   // query < entry (3-key order)
        logic key_eq;   // exact match
        logic ovl;      // closed intervals overlap
        logic ent_r_lt_pt;
        logic ent_l_gt_pt;
        logic ent_l_gt_best;
        logic ent_l_lt_best;
    } t_cmp;

endpackage

@@ rtl/core/sit_cmp.sv @@
// ----------------------------------------------------------------------------
// sit_cmp
// Shared compare unit: evaluates one stored entry against the current item.
// ----------------------------------------------------------------------------
module sit_cmp (
    input  sit_pkg::t_entry i_ent,
    input  logic [31:0]     i_left,
    input  logic [31:0]     i_right,
    input  logic [63:0]     i_owner,
    input  logic [31:0]     i_point,
    input  logic [31:0]     i_best_left,
    output sit_pkg::t_cmp   o_cmp
);
    always_comb begin
        o_cmp.key_eq = (i_left == i_ent.left) && (i_right == i_ent.right)
                       && (i_owner == i_ent.owner);
        if (i_left != i_ent.left) begin
            o_cmp.key_lt = i_left < i_ent.left;
        end else if (i_right != i_ent.right) begin
            o_cmp.key_lt = i_right < i_ent.right;
        end else begin
            o_cmp.key_lt = i_owner < i_ent.owner;
        end
        o_cmp.ovl           = (i_left <= i_ent.right) && (i_ent.left <= i_right);
        o_cmp.ent_r_lt_pt   = i_ent.right < i_point;
        o_cmp.ent_l_gt_pt   = i_ent.left > i_point;
        o_cmp.ent_l_gt_best = i_ent.left > i_best_left;
        o_cmp.ent_l_lt_best = i_ent.left < i_best_left;
    end
endmodule

@@ rtl/core/sit_ctrl.sv @@
// ----------------------------------------------------------------------------
// sit_ctrl
// Sequencer and entry memory: scans the table one entry a cycle while the
// result output is free, shifts entries for insert and delete, and emits result items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sit_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ovl_allowed,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sit_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sit_pkg::t_out_item o_out_item
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RDW   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FOUT  = 3'd5;

    sit_pkg::t_entry r_mem [sit_pkg::Capacity];
    sit_pkg::t_entry r_rd;

    logic [2:0]                r_state, n_state;
    logic [sit_pkg::CntBits-1:0] r_count, n_count;
    logic [sit_pkg::CntBits-1:0] r_idx, n_idx;
    logic [sit_pkg::CntBits-1:0] r_pos, n_pos;
    logic                      r_pos_set, n_pos_set;
    logic [sit_pkg::CntBits-1:0] r_shm, n_shm;
    logic                      r_rd_ok, n_rd_ok;
    logic [2:0]                r_cmd;
    logic [31:0]               r_l, r_r, r_pt;
    logic [63:0]               r_own;
    logic [5:0]                r_lim, r_nres, n_nres;
    logic                      r_best_ok, n_best_ok;
    logic [31:0]               r_best_l, n_best_l;
    sit_pkg::t_entry           r_best, n_best;
    logic                      r_ovalid, n_ovalid;
    sit_pkg::t_out_item        r_oitem, n_oitem;
    logic                      r_fpend, n_fpend;
    sit_pkg::t_entry           r_fent, n_fent;

    logic                      mem_we;
    logic [sit_pkg::IdxBits-1:0] mem_wa, mem_ra;
    sit_pkg::t_entry           mem_wd;
    sit_pkg::t_cmp             cmp;
    logic                      out_free;
    logic [5:0]                lim_eff;

    sit_cmp u_cmp (
        .i_ent       (r_rd),
        .i_left      (r_l),
        .i_right     (r_r),
        .i_owner     (r_own),
        .i_point     (r_pt),
        .i_best_left (r_best_l),
        .o_cmp       (cmp)
    );

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;
    assign lim_eff     = (r_lim == 6'd0 || r_lim > 6'(sit_pkg::MaxResults))
                         ? 6'(sit_pkg::MaxResults) : r_lim;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    function automatic sit_pkg::t_out_item mk(input logic [2:0] st,
                                              input logic fnd,
                                              input sit_pkg::t_entry e,
                                              input logic lst);
        sit_pkg::t_out_item o;
        o.status    = st;
        o.found     = fnd;
        o.out_left  = fnd ? e.left : 32'd0;
        o.out_right = fnd ? e.right : 32'd0;
        o.out_owner = fnd ? e.owner : 64'd0;
        o.last      = lst;
        return o;
    endfunction

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_pos_set = r_pos_set;
        n_shm     = r_shm;
        n_rd_ok   = 1'b0;
        n_nres    = r_nres;
        n_best_ok = r_best_ok;
        n_best_l  = r_best_l;
        n_best    = r_best;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_oitem   = r_oitem;
        n_fpend   = r_fpend;
        n_fent    = r_fent;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = r_rd;
        mem_ra    = r_idx[sit_pkg::IdxBits-1:0];
        case (r_state)
            S_IDLE: begin
                mem_ra = '0;
                if (i_in_valid && o_in_ready) begin
                    n_idx     = '0;
                    n_pos     = r_count;
                    n_pos_set = 1'b0;
                    n_nres    = '0;
                    n_best_ok = 1'b0;
                    n_best_l  = '0;
                    n_fpend   = 1'b0;
                    n_rd_ok   = r_count != '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // One entry per cycle through the shared compare unit while the result output is free.
                mem_ra = r_idx[sit_pkg::IdxBits-1:0] + 1'b1;
                if (r_rd_ok && out_free) begin
                    case (r_cmd)
                        sit_pkg::CMD_INSERT: begin
                            if (i_ovl_allowed ? cmp.key_eq : cmp.ovl) begin
                                n_ovalid = 1'b1;
                                n_oitem  = mk(sit_pkg::ST_DUP, 1'b0, r_rd, 1'b1);
                                n_state  = S_IDLE;
                            end else if (!r_pos_set && cmp.key_lt) begin
                                n_pos     = r_idx;
                                n_pos_set = 1'b1;
                            end
                        end
                        sit_pkg::CMD_DELETE: begin
                            if (cmp.key_eq) begin
                                n_pos     = r_idx;
                                n_pos_set = 1'b1;
                                n_shm     = r_idx;
                                n_state   = S_RDW;
                            end
                        end
                        sit_pkg::CMD_FIND: begin
                            if (cmp.ovl) begin
                                if (r_fpend) begin
                                    n_ovalid = 1'b1;
                                    n_oitem  = mk(sit_pkg::ST_OK, 1'b1, r_fent, 1'b0);
                                end
                                n_fpend = 1'b1;
                                n_fent  = r_rd;
                                n_nres  = r_nres + 6'd1;
                            end
                        end
                        sit_pkg::CMD_PRED: begin
                            if (cmp.ent_r_lt_pt && (!r_best_ok || cmp.ent_l_gt_best)) begin
                                n_best_ok = 1'b1;
                                n_best_l  = r_rd.left;
                                n_best    = r_rd;
                            end
                        end
                        default: begin
                            if (cmp.ent_l_gt_pt && (!r_best_ok || cmp.ent_l_lt_best)) begin
                                n_best_ok = 1'b1;
                                n_best_l  = r_rd.left;
                                n_best    = r_rd;
                            end
                        end
                    endcase
                end
                if (out_free && n_state == S_SCAN) begin
                    if (r_rd_ok && !(r_cmd == sit_pkg::CMD_DELETE && cmp.key_eq)) begin
                        n_idx   = r_idx + 1'b1;
                        n_rd_ok = (r_idx + 1'b1) < r_count
                                  && !(r_cmd == sit_pkg::CMD_FIND && n_nres >= lim_eff);
                    end else if (!r_rd_ok) begin
                        n_state = S_EMIT;
                    end
                end else if (!out_free) begin
                    mem_ra  = r_idx[sit_pkg::IdxBits-1:0];
                    n_rd_ok = r_rd_ok;
                end
            end
            S_RDW: begin
                // Prime the read for the shift pass.
                if (r_cmd == sit_pkg::CMD_INSERT) begin
                    n_shm  = r_count;
                    mem_ra = r_count[sit_pkg::IdxBits-1:0] - 1'b1;
                end else begin
                    mem_ra = r_shm[sit_pkg::IdxBits-1:0] + 1'b1;
                end
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_cmd == sit_pkg::CMD_INSERT) begin
                    if (r_shm == r_pos) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_pos[sit_pkg::IdxBits-1:0];
                        mem_wd  = '{left: r_l, right: r_r, owner: r_own};
                        n_count = r_count + 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_shm[sit_pkg::IdxBits-1:0];
                        mem_wd = r_rd;
                        n_shm  = r_shm - 1'b1;
                        mem_ra = r_shm[sit_pkg::IdxBits-1:0] - 2'd2;
                    end
                end else begin
                    if (r_shm + 1'b1 >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_shm[sit_pkg::IdxBits-1:0];
                        mem_wd = r_rd;
                        n_shm  = r_shm + 1'b1;
                        mem_ra = r_shm[sit_pkg::IdxBits-1:0] + 2'd2;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    case (r_cmd)
                        sit_pkg::CMD_INSERT: begin
                            if (r_shm == r_pos && r_pos_set) begin
                                n_oitem = mk(sit_pkg::ST_OK, 1'b0, r_rd, 1'b1);
                            end else if (r_count == sit_pkg::CntBits'(sit_pkg::Capacity)
                                         && r_state == S_EMIT && !r_pos_set
                                         && r_pos == r_count) begin
                                n_oitem = mk(sit_pkg::ST_FULL, 1'b0, r_rd, 1'b1);
                            end else begin
                                n_oitem = mk(sit_pkg::ST_OK, 1'b0, r_rd, 1'b1);
                            end
                        end
                        sit_pkg::CMD_DELETE: begin
                            n_oitem = mk(r_pos_set ? sit_pkg::ST_OK : sit_pkg::ST_NOTFOUND,
                                         1'b0, r_rd, 1'b1);
                        end
                        sit_pkg::CMD_FIND: begin
                            n_oitem = mk(sit_pkg::ST_OK, r_fpend, r_fent, 1'b1);
                        end
                        sit_pkg::CMD_PRED, sit_pkg::CMD_SUCC: begin
                            n_oitem = i_ovl_allowed
                                ? mk(sit_pkg::ST_DENIED, 1'b0, r_best, 1'b1)
                                : mk(sit_pkg::ST_OK, r_best_ok, r_best, 1'b1);
                        end
                        sit_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            n_oitem = mk(sit_pkg::ST_OK, 1'b0, r_rd, 1'b1);
                        end
                        default: begin
                            n_oitem = mk(sit_pkg::ST_DENIED, 1'b0, r_rd, 1'b1);
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Scan done for insert: decide full or start the shift pass.
        if (r_state == S_SCAN && n_state == S_EMIT && r_cmd == sit_pkg::CMD_INSERT) begin
            if (r_count == sit_pkg::CntBits'(sit_pkg::Capacity)) begin
                n_pos_set = 1'b0;
                n_pos     = r_count;
                n_shm     = '0;
            end else begin
                n_state = S_RDW;
            end
        end
        if (r_state == S_SHIFT && n_state == S_EMIT && r_cmd == sit_pkg::CMD_INSERT) begin
            n_pos_set = 1'b1;
            n_shm     = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_pos_set <= n_pos_set;
        r_shm     <= n_shm;
        r_rd_ok   <= n_rd_ok;
        r_nres    <= n_nres;
        r_best_ok <= n_best_ok;
        r_best_l  <= n_best_l;
        r_best    <= n_best;
        r_oitem   <= n_oitem;
        r_fpend   <= n_fpend;
        r_fent    <= n_fent;
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_in_item.command;
            r_l   <= i_in_item.left_end & sit_pkg::KeyMask;
            r_r   <= i_in_item.right_end & sit_pkg::KeyMask;
            r_own <= i_in_item.owner_id;
            r_pt  <= i_in_item.query_point & sit_pkg::KeyMask;
            r_lim <= i_in_item.match_limit;
        end
    end

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1,
                 r_count <= sit_pkg::CntBits'(sit_pkg::Capacity), "entry count over capacity")
    `ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready,
                 "ready while busy")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_out_ready,
                 r_ovalid && $stable(r_oitem), "result dropped while stalled")

endmodule

@@ rtl/core/sorted_interval_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_table_top
// Sorted interval table with APB register port and valid/ready channels.
// ----------------------------------------------------------------------------
// One item at a time: a command scans the stored entries one per cycle
// through a single compare unit and, for insert or delete, walks a second
// pass moving one entry per cycle through the entry memory.
// A stalled result holds the sequencer and the input.
// The register at address 0 holds overlaps_allowed.
module sorted_interval_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sit_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sit_pkg::t_out_item o_out_item
);
    logic r_ovl_allowed;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, r_ovl_allowed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl_allowed <= 1'b0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_ovl_allowed <= pwdata[0];
        end
    end

    sit_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ovl_allowed (r_ovl_allowed),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item)
    );
endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives table commands with random idling on both channels, predicts every
// result item from a local copy of the interval table and checks field by
// field, walking both settings of overlaps_allowed.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] CMD_BAD_A = 3'd6;
    localparam logic [2:0] CMD_BAD_B = 3'd7;
    localparam logic [1:0] ADDR_OVERLAPS = 2'd0;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        sit_pkg::t_in_item  item;
        logic               has_expect;
        sit_pkg::t_out_item expect_out;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    sit_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    sit_pkg::t_out_item o_out_item;

    sit_pkg::t_entry    table_q[$];
    logic               allow_overlap;
    sit_pkg::t_out_item pending_results[$];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    bit                 hold_off_rx = 0;
    bit                 quiet_tail = 0;
    t_row               rows[$];

    sorted_interval_table_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic sit_pkg::t_out_item make_result(logic [2:0] st, logic fnd,
                                                       sit_pkg::t_entry e, logic lst);
        sit_pkg::t_out_item r;
        r.status = st;
        r.found = fnd;
        r.out_left = fnd ? e.left : '0;
        r.out_right = fnd ? e.right : '0;
        r.out_owner = fnd ? e.owner : '0;
        r.last = lst;
        return r;
    endfunction

    function automatic int order_cmp(sit_pkg::t_entry a, sit_pkg::t_entry b);
        if (a.left != b.left) return a.left < b.left ? -1 : 1;
        if (a.right != b.right) return a.right < b.right ? -1 : 1;
        if (a.owner != b.owner) return a.owner < b.owner ? -1 : 1;
        return 0;
    endfunction

    function automatic bit intervals_overlap(logic [31:0] al, logic [31:0] ar,
                                             logic [31:0] bl, logic [31:0] br);
        return al <= br && bl <= ar;
    endfunction

    task automatic predict_table(sit_pkg::t_in_item it);
        sit_pkg::t_entry q;
        sit_pkg::t_entry none;
        int pos;
        int best;
        int lim;
        int hits;
        bit clash;
        q.left = it.left_end & sit_pkg::KeyMask;
        q.right = it.right_end & sit_pkg::KeyMask;
        q.owner = it.owner_id;
        none = '0;
        case (it.command)
            sit_pkg::CMD_INSERT: begin
                clash = 0;
                foreach (table_q[i])
                    if (allow_overlap ? order_cmp(q, table_q[i]) == 0
                        : intervals_overlap(q.left, q.right, table_q[i].left, table_q[i].right))
                        clash = 1;
                if (clash) begin
                    pending_results.push_back(make_result(sit_pkg::ST_DUP, 0, none, 1));
                end else if (table_q.size() >= sit_pkg::Capacity) begin
                    pending_results.push_back(make_result(sit_pkg::ST_FULL, 0, none, 1));
                end else begin
                    pos = table_q.size();
                    foreach (table_q[i])
                        if (pos == table_q.size() && order_cmp(q, table_q[i]) < 0) pos = i;
                    table_q.insert(pos, q);
                    pending_results.push_back(make_result(sit_pkg::ST_OK, 0, none, 1));
                end
            end
            sit_pkg::CMD_DELETE: begin
                pos = -1;
                foreach (table_q[i])
                    if (pos < 0 && order_cmp(q, table_q[i]) == 0) pos = i;
                if (pos < 0) begin
                    pending_results.push_back(make_result(sit_pkg::ST_NOTFOUND, 0, none, 1));
                end else begin
                    table_q.delete(pos);
                    pending_results.push_back(make_result(sit_pkg::ST_OK, 0, none, 1));
                end
            end
            sit_pkg::CMD_FIND: begin
                lim = (it.match_limit == 0 || it.match_limit > sit_pkg::MaxResults)
                    ? sit_pkg::MaxResults : int'(it.match_limit);
                hits = 0;
                foreach (table_q[i])
                    if (hits < lim && intervals_overlap(q.left, q.right,
                                                        table_q[i].left, table_q[i].right)) begin
                        pending_results.push_back(make_result(sit_pkg::ST_OK, 1, table_q[i], 0));
                        hits++;
                    end
                if (hits == 0) pending_results.push_back(make_result(sit_pkg::ST_OK, 0, none, 1));
                else pending_results[$].last = 1'b1;
            end
            sit_pkg::CMD_PRED, sit_pkg::CMD_SUCC: begin
                if (allow_overlap) begin
                    pending_results.push_back(make_result(sit_pkg::ST_DENIED, 0, none, 1));
                end else begin
                    best = -1;
                    foreach (table_q[i]) begin
                        if (it.command == sit_pkg::CMD_PRED) begin
                            if (table_q[i].right < (it.query_point & sit_pkg::KeyMask) &&
                                (best < 0 || table_q[best].left < table_q[i].left)) best = i;
                        end else begin
                            if (table_q[i].left > (it.query_point & sit_pkg::KeyMask) &&
                                (best < 0 || table_q[best].left > table_q[i].left)) best = i;
                        end
                    end
                    pending_results.push_back(make_result(sit_pkg::ST_OK, best >= 0,
                                              best >= 0 ? table_q[best] : none, 1));
                end
            end
            sit_pkg::CMD_CLEAR: begin
                table_q.delete();
                pending_results.push_back(make_result(sit_pkg::ST_OK, 0, none, 1));
            end
            default: pending_results.push_back(make_result(sit_pkg::ST_DENIED, 0, none, 1));
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Receiver with random stalls and a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_rx) begin
            i_out_ready <= 1'b0;
        end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Check accepted results.
    always @(posedge i_clk) begin
        sit_pkg::t_out_item w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 64'(o_out_item.status), 64'd0);
            end else begin
                w = pending_results.pop_front();
                if (o_out_item.status !== w.status)
                    report_mismatch("status", 64'(o_out_item.status), 64'(w.status));
                if (o_out_item.found !== w.found)
                    report_mismatch("found", 64'(o_out_item.found), 64'(w.found));
                if (o_out_item.out_left !== w.out_left)
                    report_mismatch("out_left", 64'(o_out_item.out_left), 64'(w.out_left));
                if (o_out_item.out_right !== w.out_right)
                    report_mismatch("out_right", 64'(o_out_item.out_right), 64'(w.out_right));
                if (o_out_item.out_owner !== w.out_owner)
                    report_mismatch("out_owner", o_out_item.out_owner, w.out_owner);
                if (o_out_item.last !== w.last)
                    report_mismatch("last", 64'(o_out_item.last), 64'(w.last));
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_overlaps(logic value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_OVERLAPS;
        pwdata <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        allow_overlap = value;
    endtask

    task automatic send_item(sit_pkg::t_in_item it, bit may_idle);
        if (may_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_table(it);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic sit_pkg::t_in_item build_item(logic [2:0] cmd, logic [31:0] l,
                                                     logic [31:0] r, logic [63:0] own,
                                                     logic [31:0] pt, logic [5:0] lim);
        sit_pkg::t_in_item it;
        it.command = cmd;
        it.left_end = l;
        it.right_end = r;
        it.owner_id = own;
        it.query_point = pt;
        it.match_limit = lim;
        return it;
    endfunction

    function automatic sit_pkg::t_in_item random_item(bit dense);
        sit_pkg::t_in_item it;
        int pick;
        logic [31:0] base;
        it.left_end = $urandom;
        it.right_end = $urandom;
        it.owner_id = {$urandom, $urandom};
        it.query_point = $urandom;
        it.match_limit = 6'($urandom_range(0, 63));
        pick = int'($urandom_range(0, 99));
        if (pick < 45) it.command = sit_pkg::CMD_INSERT;
        else if (pick < 55) it.command = sit_pkg::CMD_DELETE;
        else if (pick < 75) it.command = sit_pkg::CMD_FIND;
        else if (pick < 84) it.command = sit_pkg::CMD_PRED;
        else if (pick < 93) it.command = sit_pkg::CMD_SUCC;
        else if (pick < 96) it.command = sit_pkg::CMD_CLEAR;
        else it.command = $urandom_range(0, 1) ? CMD_BAD_A : CMD_BAD_B;
        if (dense) begin
            base = $urandom_range(0, 2000);
            it.left_end = base;
            it.right_end = base + $urandom_range(0, 20);
            it.owner_id = 64'($urandom_range(0, 3));
            it.query_point = $urandom_range(0, 2100);
            it.match_limit = 6'($urandom_range(0, 8));
        end
        if (it.command == sit_pkg::CMD_DELETE && table_q.size() != 0
            && $urandom_range(0, 2) != 0) begin
            pick = int'($urandom_range(0, table_q.size() - 1));
            it.left_end = table_q[pick].left;
            it.right_end = table_q[pick].right;
            it.owner_id = table_q[pick].owner;
        end
        return it;
    endfunction

    task automatic add_row(sit_pkg::t_in_item it, logic has, sit_pkg::t_out_item w);
        t_row row;
        row.item = it;
        row.has_expect = has;
        row.expect_out = w;
        rows.push_back(row);
    endtask

    initial begin
        sit_pkg::t_out_item ok1;
        sit_pkg::t_out_item none;
        sit_pkg::t_entry    zero_e;
        zero_e = '0;
        ok1 = make_result(sit_pkg::ST_OK, 0, zero_e, 1);
        none = '0;
        allow_overlap = 1'b0;
        add_row(build_item(sit_pkg::CMD_FIND, 0, 32'hFFFF_FFFF, 0, 0, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_PRED, 0, 0, 0, 32'hFFFF_FFFF, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_DELETE, 5, 6, 7, 0, 0), 1,
                make_result(sit_pkg::ST_NOTFOUND, 0, zero_e, 1));
        add_row(build_item(sit_pkg::CMD_INSERT, 0, 0, 0, 0, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF, 0, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_INSERT, 0, 0, 1, 0, 0), 1,
                make_result(sit_pkg::ST_DUP, 0, zero_e, 1));
        add_row(build_item(sit_pkg::CMD_INSERT, 500, 100, 9, 0, 0), 0, none);
        add_row(build_item(sit_pkg::CMD_INSERT, 1000, 2000, 3, 0, 0), 0, none);
        add_row(build_item(sit_pkg::CMD_INSERT, 1500, 1600, 4, 0, 0), 1,
                make_result(sit_pkg::ST_DUP, 0, zero_e, 1));
        add_row(build_item(sit_pkg::CMD_FIND, 0, 32'hFFFF_FFFF, 0, 0, 0), 0, none);
        add_row(build_item(sit_pkg::CMD_FIND, 0, 32'hFFFF_FFFF, 0, 0, 1), 0, none);
        add_row(build_item(sit_pkg::CMD_FIND, 10, 20, 0, 0, 63), 1, ok1);
        add_row(build_item(sit_pkg::CMD_PRED, 0, 0, 0, 1000, 0), 0, none);
        add_row(build_item(sit_pkg::CMD_SUCC, 0, 0, 0, 600, 0), 0, none);
        add_row(build_item(sit_pkg::CMD_SUCC, 0, 0, 0, 32'hFFFF_FFFF, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_PRED, 0, 0, 0, 0, 0), 1, ok1);
        add_row(build_item(CMD_BAD_A, 1, 2, 3, 4, 5), 1,
                make_result(sit_pkg::ST_DENIED, 0, zero_e, 1));
        add_row(build_item(CMD_BAD_B, 1, 2, 3, 4, 5), 1,
                make_result(sit_pkg::ST_DENIED, 0, zero_e, 1));
        add_row(build_item(sit_pkg::CMD_DELETE, 1000, 2000, 3, 0, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 1, ok1);
        add_row(build_item(sit_pkg::CMD_FIND, 0, 32'hFFFF_FFFF, 0, 0, 0), 1, ok1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_item(rows[i].item, 1);
            if (rows[i].has_expect && pending_results[$] != rows[i].expect_out)
                report_mismatch("directed prediction", 64'(i), 64'd0);
        end
        drain_results();

        // Fill past capacity; stall the receiver meanwhile.
        fork
            begin
                hold_off_rx = 1;
                repeat (400) @(posedge i_clk);
                hold_off_rx = 0;
            end
            begin
                for (int k = 0; k < sit_pkg::Capacity + 2; k++)
                    send_item(build_item(sit_pkg::CMD_INSERT, 32'(k * 10), 32'(k * 10 + 5),
                                         64'(k), 0, 0), 0);
            end
        join
        send_item(build_item(sit_pkg::CMD_FIND, 0, 32'hFFFF_FFFF, 0, 0, 0), 0);
        send_item(build_item(sit_pkg::CMD_PRED, 0, 0, 0, 32'hFFFF_FFFF, 0), 0);
        send_item(build_item(sit_pkg::CMD_INSERT, 1, 2, 5, 0, 0), 0);
        drain_results();

        // Overlaps allowed: duplicates only, and predecessor and successor searches are refused.
        write_overlaps(1'b1);
        send_item(build_item(sit_pkg::CMD_INSERT, 3, 4, 77, 0, 0), 0);
        send_item(build_item(sit_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 0);
        send_item(build_item(sit_pkg::CMD_INSERT, 3, 4, 77, 0, 0), 0);
        send_item(build_item(sit_pkg::CMD_INSERT, 3, 4, 77, 0, 0), 0);
        send_item(build_item(sit_pkg::CMD_INSERT, 3, 4, 76, 0, 0), 0);
        send_item(build_item(sit_pkg::CMD_SUCC, 0, 0, 0, 0, 0), 0);
        for (int k = 0; k < 20; k++) send_item(random_item(1), 1);
        drain_results();

        write_overlaps(1'b0);
        send_item(build_item(sit_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 0);
        for (int k = 0; k < 15; k++) send_item(random_item($urandom_range(0, 3) != 0), 1);
        drain_results();

        write_overlaps(1'b1);
        quiet_tail = 1;
        for (int k = 0; k < 10; k++) send_item(random_item(1), 0);
        drain_results();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
